[rtl/detector_proposal_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Detector proposal decoder assertion macros
// Short forms for same-cycle and next-cycle implications, reset disabled.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_PROPOSAL_DECODER_MACROS_SVH
`define DETECTOR_PROPOSAL_DECODER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dpd_pkg.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder package
// Widths, register codes, configuration and record types shared by the block.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // limits of the stream
  localparam int unsigned MaxClasses   = 128;
  localparam int unsigned MaxProposals = 16384;

  // field widths
  localparam int unsigned VAL_W     = 23;
  localparam int unsigned CLS_W     = 7;
  localparam int unsigned NUM_W     = 14;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CNT_MAX   = 255;
  localparam int unsigned BOX_VALS  = 4;
  localparam int unsigned BOX_IDX_W = 2;
  localparam int unsigned THR_W     = 13;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned EXT_W     = 13;
  localparam int unsigned EXT_MAX   = 4096;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned LEN_W     = 13;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MASK_W     = 2 * CFG_DATA_W;

  // fixed point datapath
  localparam int unsigned FRAC_SHIFT = 25;
  localparam int unsigned DIFF_W     = VAL_W + 3;           // 2*c - s, signed
  localparam int unsigned KS_W       = SCALE_W + 1;         // scale as signed
  localparam int unsigned LO_W       = DIFF_W + KS_W;       // signed edge product
  localparam int unsigned LOC_W      = LO_W - 1;            // edge after clamp at zero
  localparam int unsigned SZ_W       = VAL_W + 1 + SCALE_W; // 2*s*k, unsigned
  localparam int unsigned ROOM_W     = LOC_W + 2;           // signed room to frame edge
  localparam int unsigned PIX_W      = LOC_W - FRAC_SHIFT;  // edge in whole pixels

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_THRESHOLD  = 3'd0,
    CFG_SCALE_HORIZONTAL = 3'd1,
    CFG_SCALE_VERTICAL   = 3'd2,
    CFG_FRAME_WIDTH      = 3'd3,
    CFG_FRAME_HEIGHT     = 3'd4,
    CFG_CLASS_MASK_LOW   = 3'd5,
    CFG_CLASS_MASK_HIGH  = 3'd6,
    CFG_CLASS_FILTER_ON  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]   score_threshold;
    logic [SCALE_W-1:0] scale_horizontal;
    logic [SCALE_W-1:0] scale_vertical;
    logic [EXT_W-1:0]   frame_width;
    logic [EXT_W-1:0]   frame_height;
    logic [MASK_W-1:0]  class_mask;
    logic               class_filter_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    score_threshold:  THR_W'(1229),
    scale_horizontal: SCALE_W'(4096),
    scale_vertical:   SCALE_W'(4096),
    frame_width:      EXT_W'(640),
    frame_height:     EXT_W'(640),
    class_mask:       MASK_W'(4),
    class_filter_on:  1'b1
  };

  // accepted proposal handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] xc;
    logic [VAL_W-1:0] yc;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] h;
    logic [CLS_W-1:0] cls;
    logic [VAL_W-1:0] score;
    logic [NUM_W-1:0] num;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // back stage after the multipliers
  typedef struct packed {
    logic signed [LO_W-1:0] lo_x;
    logic [SZ_W-1:0]        sz_x;
    logic signed [LO_W-1:0] lo_y;
    logic [SZ_W-1:0]        sz_y;
    logic [CLS_W-1:0]       cls;
    logic [VAL_W-1:0]       score;
    logic [NUM_W-1:0]       num;
  } mul_t;

  // back stage after the edge clamp
  typedef struct packed {
    logic [POS_W-1:0]         pos_x;
    logic signed [ROOM_W-1:0] room_x;
    logic [SZ_W-1:0]          sz_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [ROOM_W-1:0] room_y;
    logic [SZ_W-1:0]          sz_y;
    logic [CLS_W-1:0]         cls;
    logic [VAL_W-1:0]         score;
    logic [NUM_W-1:0]         num;
  } edge_t;

  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [LEN_W-1:0] width;
    logic [LEN_W-1:0] height;
    logic [CLS_W-1:0] cls;
    logic [VAL_W-1:0] score;
    logic [NUM_W-1:0] num;
  } result_t;

  // frame size forced into one to the largest frame
  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    if (v == '0) begin
      r = EXT_W'(1);
    end else if (v > EXT_W'(EXT_MAX)) begin
      r = EXT_W'(EXT_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/dpd_front.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder front
// Takes elements, holds the box, tracks the best class and decides per proposal.
// ----------------------------------------------------------------------------
module dpd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpd_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dpd_pkg::VAL_W-1:0]    element_value_i,
  input  logic                         last_element_i,
  input  logic                         first_of_frame_i,
  input  dpd_pkg::q_status_t           q_status_i,
  output dpd_pkg::push_t               push_o
);

  logic [dpd_pkg::CNT_W-1:0] cnt_q;
  logic [dpd_pkg::NUM_W-1:0] prop_q;
  logic [dpd_pkg::VAL_W-1:0] best_q;
  logic [dpd_pkg::CLS_W-1:0] cls_q;
  logic                      seen_q;
  logic [dpd_pkg::VAL_W-1:0] held_q [dpd_pkg::BOX_VALS];

  logic                      take;
  logic [dpd_pkg::CNT_W-1:0] cnt_e;
  logic [dpd_pkg::NUM_W-1:0] prop_e;
  logic [dpd_pkg::VAL_W-1:0] best_e;
  logic [dpd_pkg::CLS_W-1:0] cls_e;
  logic                      seen_e;
  logic [dpd_pkg::CNT_W-1:0] cls_off;
  logic                      is_box;
  logic                      better;
  logic [dpd_pkg::VAL_W-1:0] best_d;
  logic [dpd_pkg::CLS_W-1:0] cls_d;
  logic                      seen_d;
  logic [dpd_pkg::CNT_W-1:0] cnt_d;
  logic [dpd_pkg::NUM_W-1:0] prop_d;
  logic                      accept;

  // a transfer needs room in the queue
  assign take       = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;

  // start of frame clears the proposal state before this element
  always_comb begin
    cnt_e  = first_of_frame_i ? '0 : cnt_q;
    prop_e = first_of_frame_i ? '0 : prop_q;
    best_e = first_of_frame_i ? '0 : best_q;
    cls_e  = first_of_frame_i ? '0 : cls_q;
    seen_e = first_of_frame_i ? 1'b0 : seen_q;
  end

  // running argmax, strict greater so the first class wins a tie
  always_comb begin
    cls_off = cnt_e - dpd_pkg::CNT_W'(dpd_pkg::BOX_VALS);
    is_box  = cnt_e < dpd_pkg::CNT_W'(dpd_pkg::BOX_VALS);
    better  = !is_box && (cls_off < dpd_pkg::CNT_W'(dpd_pkg::MaxClasses)) &&
              (element_value_i > best_e);
    best_d  = better ? element_value_i : best_e;
    cls_d   = better ? cls_off[dpd_pkg::CLS_W-1:0] : cls_e;
    seen_d  = seen_e || better;
    cnt_d   = (cnt_e == dpd_pkg::CNT_W'(dpd_pkg::CNT_MAX)) ? cnt_e : cnt_e + 1'b1;
    prop_d  = (prop_e == dpd_pkg::NUM_W'(dpd_pkg::MaxProposals - 1)) ? '0 : prop_e + 1'b1;
  end

  // proposal verdict: score above zero, threshold and class mask
  always_comb begin
    accept = seen_d &&
             (best_d >= dpd_pkg::VAL_W'(cfg_i.score_threshold)) &&
             (!cfg_i.class_filter_on || cfg_i.class_mask[cls_d]);
  end

  // record for the back end
  always_comb begin
    push_o.valid     = take && last_element_i && accept;
    push_o.rec.xc    = held_q[0];
    push_o.rec.yc    = held_q[1];
    push_o.rec.w     = held_q[2];
    push_o.rec.h     = held_q[3];
    push_o.rec.cls   = cls_d;
    push_o.rec.score = best_d;
    push_o.rec.num   = prop_e;
  end

  // proposal state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prop_q <= '0;
      best_q <= '0;
      cls_q  <= '0;
      seen_q <= 1'b0;
    end else if (take) begin
      if (last_element_i) begin
        cnt_q  <= '0;
        prop_q <= prop_d;
        best_q <= '0;
        cls_q  <= '0;
        seen_q <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        prop_q <= prop_e;
        best_q <= best_d;
        cls_q  <= cls_d;
        seen_q <= seen_d;
      end
    end
  end

  // box values of the current proposal
  always_ff @(posedge clk_i) begin
    if (take && is_box) begin
      held_q[cnt_e[dpd_pkg::BOX_IDX_W-1:0]] <= element_value_i;
    end
  end

endmodule

[rtl/dpd_queue.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder queue
// Short first-in first-out buffer of accepted proposals between front and back.
// ----------------------------------------------------------------------------
module dpd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpd_pkg::push_t     push_i,
  input  logic               pop_i,
  output dpd_pkg::q_status_t status_o,
  output dpd_pkg::rec_t      rec_o
);

  dpd_pkg::rec_t              mem_q [dpd_pkg::QDEPTH];
  logic [dpd_pkg::QPTR_W-1:0] wr_q;
  logic [dpd_pkg::QPTR_W-1:0] rd_q;
  logic [dpd_pkg::QCNT_W-1:0] count_q;

  assign status_o.full      = count_q == dpd_pkg::QCNT_W'(dpd_pkg::QDEPTH);
  assign status_o.not_empty = count_q != '0;
  assign rec_o              = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i.valid && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.valid && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.rec;
    end
  end

endmodule

[rtl/dpd_back.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder back
// Scales and clips the box in three elastic stages ending in the output register.
// ----------------------------------------------------------------------------
module dpd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpd_pkg::cfg_t               cfg_i,
  input  dpd_pkg::q_status_t          q_status_i,
  input  dpd_pkg::rec_t               rec_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dpd_pkg::result_t            result_o
);

  logic             mul_v_q;
  logic             edge_v_q;
  logic             out_v_q;
  dpd_pkg::mul_t    mul_q;
  dpd_pkg::edge_t   edge_q;
  dpd_pkg::result_t out_q;

  logic ready_out;
  logic ready_edge;
  logic ready_mul;

  dpd_pkg::mul_t    mul_d;
  dpd_pkg::edge_t   edge_d;
  dpd_pkg::result_t out_d;

  logic signed [dpd_pkg::DIFF_W-1:0] diff_x;
  logic signed [dpd_pkg::DIFF_W-1:0] diff_y;
  logic signed [dpd_pkg::KS_W-1:0]   k_x;
  logic signed [dpd_pkg::KS_W-1:0]   k_y;

  logic [dpd_pkg::EXT_W-1:0]  ext_x;
  logic [dpd_pkg::EXT_W-1:0]  ext_y;
  logic [dpd_pkg::EXT_W-1:0]  lim_x;
  logic [dpd_pkg::EXT_W-1:0]  lim_y;
  logic [dpd_pkg::LOC_W-1:0]  loc_x;
  logic [dpd_pkg::LOC_W-1:0]  loc_y;
  logic [dpd_pkg::PIX_W-1:0]  pix_x;
  logic [dpd_pkg::PIX_W-1:0]  pix_y;

  logic signed [dpd_pkg::ROOM_W-1:0] szs_x;
  logic signed [dpd_pkg::ROOM_W-1:0] szs_y;
  logic signed [dpd_pkg::ROOM_W-1:0] szm_x;
  logic signed [dpd_pkg::ROOM_W-1:0] szm_y;

  // stage handshake, each stage moves when the next one frees up
  assign ready_out  = !out_v_q || !out_stall_i;
  assign ready_edge = !edge_v_q || ready_out;
  assign ready_mul  = !mul_v_q || ready_edge;
  assign pop_o      = q_status_i.not_empty && ready_mul;

  // stage one: edge and size products
  always_comb begin
    diff_x = $signed({2'b00, rec_i.xc, 1'b0}) - $signed({3'b000, rec_i.w});
    diff_y = $signed({2'b00, rec_i.yc, 1'b0}) - $signed({3'b000, rec_i.h});
    k_x    = $signed({1'b0, cfg_i.scale_horizontal});
    k_y    = $signed({1'b0, cfg_i.scale_vertical});
    mul_d.lo_x  = diff_x * k_x;
    mul_d.lo_y  = diff_y * k_y;
    mul_d.sz_x  = {rec_i.w, 1'b0} * cfg_i.scale_horizontal;
    mul_d.sz_y  = {rec_i.h, 1'b0} * cfg_i.scale_vertical;
    mul_d.cls   = rec_i.cls;
    mul_d.score = rec_i.score;
    mul_d.num   = rec_i.num;
  end

  // stage two: clamp edge at zero, room to the far edge, pixel edge limit
  always_comb begin
    ext_x = dpd_pkg::clamp_extent(cfg_i.frame_width);
    ext_y = dpd_pkg::clamp_extent(cfg_i.frame_height);
    lim_x = ext_x - 1'b1;
    lim_y = ext_y - 1'b1;
    loc_x = mul_q.lo_x[dpd_pkg::LO_W-1] ? '0 : mul_q.lo_x[dpd_pkg::LOC_W-1:0];
    loc_y = mul_q.lo_y[dpd_pkg::LO_W-1] ? '0 : mul_q.lo_y[dpd_pkg::LOC_W-1:0];
    pix_x = loc_x[dpd_pkg::LOC_W-1:dpd_pkg::FRAC_SHIFT];
    pix_y = loc_y[dpd_pkg::LOC_W-1:dpd_pkg::FRAC_SHIFT];
    edge_d.room_x = $signed({{(dpd_pkg::ROOM_W - dpd_pkg::EXT_W - dpd_pkg::FRAC_SHIFT){1'b0}},
                             ext_x, {dpd_pkg::FRAC_SHIFT{1'b0}}}) -
                    $signed({2'b00, loc_x});
    edge_d.room_y = $signed({{(dpd_pkg::ROOM_W - dpd_pkg::EXT_W - dpd_pkg::FRAC_SHIFT){1'b0}},
                             ext_y, {dpd_pkg::FRAC_SHIFT{1'b0}}}) -
                    $signed({2'b00, loc_y});
    edge_d.pos_x = (pix_x > dpd_pkg::PIX_W'(lim_x)) ? lim_x[dpd_pkg::POS_W-1:0]
                                                    : pix_x[dpd_pkg::POS_W-1:0];
    edge_d.pos_y = (pix_y > dpd_pkg::PIX_W'(lim_y)) ? lim_y[dpd_pkg::POS_W-1:0]
                                                    : pix_y[dpd_pkg::POS_W-1:0];
    edge_d.sz_x  = mul_q.sz_x;
    edge_d.sz_y  = mul_q.sz_y;
    edge_d.cls   = mul_q.cls;
    edge_d.score = mul_q.score;
    edge_d.num   = mul_q.num;
  end

  // stage three: size limited by room, saturated at zero
  always_comb begin
    szs_x = $signed({{(dpd_pkg::ROOM_W - dpd_pkg::SZ_W){1'b0}}, edge_q.sz_x});
    szs_y = $signed({{(dpd_pkg::ROOM_W - dpd_pkg::SZ_W){1'b0}}, edge_q.sz_y});
    szm_x = (szs_x > edge_q.room_x) ? edge_q.room_x : szs_x;
    szm_y = (szs_y > edge_q.room_y) ? edge_q.room_y : szs_y;
    out_d.left   = edge_q.pos_x;
    out_d.top    = edge_q.pos_y;
    out_d.width  = szm_x[dpd_pkg::ROOM_W-1] ? '0
                 : szm_x[dpd_pkg::FRAC_SHIFT+dpd_pkg::LEN_W-1:dpd_pkg::FRAC_SHIFT];
    out_d.height = szm_y[dpd_pkg::ROOM_W-1] ? '0
                 : szm_y[dpd_pkg::FRAC_SHIFT+dpd_pkg::LEN_W-1:dpd_pkg::FRAC_SHIFT];
    out_d.cls    = edge_q.cls;
    out_d.score  = edge_q.score;
    out_d.num    = edge_q.num;
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q  <= 1'b0;
      edge_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ready_mul) begin
        mul_v_q <= pop_o;
      end
      if (ready_edge) begin
        edge_v_q <= mul_v_q;
      end
      if (ready_out) begin
        out_v_q <= edge_v_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mul_q <= mul_d;
    end
    if (ready_edge && mul_v_q) begin
      edge_q <= edge_d;
    end
    if (ready_out && edge_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign result_o    = out_q;

endmodule

[rtl/detector_proposal_decoder.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder
// Decodes a streamed detector output into scaled, clipped, thresholded boxes.
// ----------------------------------------------------------------------------
// Input channel: one element per transfer (in_valid_i high, in_stall_o low):
// centre x, centre y, width, height, then one score per class; last_element_i
// marks the final score of a proposal and first_of_frame_i restarts numbering.
// One element is taken every cycle while the four-entry proposal queue has room.
// Output channel: at most one result per proposal, a transfer when out_valid_o
// is high and out_stall_i is low. An accepted proposal passes from the queue
// through the multiply, edge clamp and output register stages.
// A stalled result holds; the stages behind it and then the queue fill, and
// in_stall_o rises only once the queue is full.
// Configuration: write at cfg_valid_i with cfg_ready_o always high, register
// index on cfg_index_i; write only while no proposal is in flight.
// Reset clears all proposal state, the queue and the pipeline, and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module detector_proposal_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // element input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dpd_pkg::VAL_W-1:0]        element_value_i,
  input  logic                             last_element_i,
  input  logic                             first_of_frame_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dpd_pkg::POS_W-1:0]        box_left_o,
  output logic [dpd_pkg::POS_W-1:0]        box_top_o,
  output logic [dpd_pkg::LEN_W-1:0]        box_width_o,
  output logic [dpd_pkg::LEN_W-1:0]        box_height_o,
  output logic [dpd_pkg::CLS_W-1:0]        class_index_o,
  output logic [dpd_pkg::VAL_W-1:0]        best_score_o,
  output logic [dpd_pkg::NUM_W-1:0]        proposal_number_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dpd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dpd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  dpd_pkg::cfg_t      cfg_q;
  dpd_pkg::push_t     push;
  dpd_pkg::q_status_t q_status;
  dpd_pkg::rec_t      head;
  dpd_pkg::result_t   result;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpd_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (dpd_pkg::cfg_idx_e'(cfg_index_i))
        dpd_pkg::CFG_SCORE_THRESHOLD: begin
          cfg_q.score_threshold <= cfg_data_i[dpd_pkg::THR_W-1:0];
        end
        dpd_pkg::CFG_SCALE_HORIZONTAL: begin
          cfg_q.scale_horizontal <= cfg_data_i[dpd_pkg::SCALE_W-1:0];
        end
        dpd_pkg::CFG_SCALE_VERTICAL: begin
          cfg_q.scale_vertical <= cfg_data_i[dpd_pkg::SCALE_W-1:0];
        end
        dpd_pkg::CFG_FRAME_WIDTH: begin
          cfg_q.frame_width <= cfg_data_i[dpd_pkg::EXT_W-1:0];
        end
        dpd_pkg::CFG_FRAME_HEIGHT: begin
          cfg_q.frame_height <= cfg_data_i[dpd_pkg::EXT_W-1:0];
        end
        dpd_pkg::CFG_CLASS_MASK_LOW: begin
          cfg_q.class_mask[dpd_pkg::CFG_DATA_W-1:0] <= cfg_data_i;
        end
        dpd_pkg::CFG_CLASS_MASK_HIGH: begin
          cfg_q.class_mask[dpd_pkg::MASK_W-1:dpd_pkg::CFG_DATA_W] <= cfg_data_i;
        end
        dpd_pkg::CFG_CLASS_FILTER_ON: begin
          cfg_q.class_filter_on <= cfg_data_i[0];
        end
      endcase
    end
  end

  // element intake and per proposal verdict
  dpd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .element_value_i  (element_value_i),
    .last_element_i   (last_element_i),
    .first_of_frame_i (first_of_frame_i),
    .q_status_i       (q_status),
    .push_o           (push)
  );

  // accepted proposals waiting for the back end
  dpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (q_status),
    .rec_o    (head)
  );

  // box scaling and clipping
  dpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .rec_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign box_left_o        = result.left;
  assign box_top_o         = result.top;
  assign box_width_o       = result.width;
  assign box_height_o      = result.height;
  assign class_index_o     = result.cls;
  assign best_score_o      = result.score;
  assign proposal_number_o = result.num;

endmodule

[rtl/dpd_checker.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "detector_proposal_decoder_macros.svh"

module dpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [dpd_pkg::POS_W-1:0]   box_left_o,
  input logic [dpd_pkg::POS_W-1:0]   box_top_o,
  input logic [dpd_pkg::LEN_W-1:0]   box_width_o,
  input logic [dpd_pkg::LEN_W-1:0]   box_height_o,
  input logic [dpd_pkg::CLS_W-1:0]   class_index_o,
  input logic [dpd_pkg::VAL_W-1:0]   best_score_o,
  input logic [dpd_pkg::NUM_W-1:0]   proposal_number_o
);

  // a stalled result holds until its transfer
  `DPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(box_left_o) && $stable(box_top_o) && $stable(box_width_o) && $stable(box_height_o) && $stable(class_index_o) && $stable(best_score_o) && $stable(proposal_number_o), "stalled result changed")

  // only proposals with a score above zero come out
  `DPD_ASSERT_NOW(a_score_nonzero, clk_i, rst_ni, out_valid_o, best_score_o != '0, "result with zero score")

  // clipped sizes never exceed the largest frame
  `DPD_ASSERT_NOW(a_size_range, clk_i, rst_ni, out_valid_o, (box_width_o <= dpd_pkg::LEN_W'(dpd_pkg::EXT_MAX)) && (box_height_o <= dpd_pkg::LEN_W'(dpd_pkg::EXT_MAX)), "box size past frame limit")

endmodule

bind detector_proposal_decoder dpd_checker u_dpd_checker (.*);

[tb/detector_proposal_decoder_tb.sv]
// ----------------------------------------------------------------------------
// Detector proposal decoder testbench
// Streams proposals of box values and class scores through the decoder, at
// random rates on both sides, under several register settings, and checks
// every emitted box against a cycle-free prediction of argmax, threshold,
// class mask, scaling and clipping.
// ----------------------------------------------------------------------------
module detector_proposal_decoder_tb;
  import dpd_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1850;
  localparam int unsigned PHASE_ITEMS     = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_LIMIT     = 1000;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned MISMATCH_REPORTS = 10;
  localparam int unsigned IDLE_PERCENT    = 17;
  localparam int unsigned CALM_PHASE      = 3;

  // --------------------------------------------------------------------------
  // prediction of decoded boxes and comparison with the block
  // --------------------------------------------------------------------------
  class box_scoreboard;
    cfg_t             regs;
    int unsigned      element_count;
    int unsigned      proposal_count;
    logic [VAL_W-1:0] held_box [BOX_VALS];
    logic [VAL_W-1:0] lead_score;
    logic [CLS_W-1:0] lead_class;
    bit               score_seen;
    result_t          expected_boxes [$];
    int unsigned      failures;
    int unsigned      boxes_checked;
    int unsigned      boxes_predicted;
    int unsigned      boxes_rejected;
    int unsigned      proposals_closed;

    function new();
      regs = CFG_RESET;
      proposal_count = 0;
      foreach (held_box[i]) held_box[i] = '0;
      start_proposal();
      failures = 0;
      boxes_checked = 0;
      boxes_predicted = 0;
      boxes_rejected = 0;
      proposals_closed = 0;
    endfunction

    function void start_proposal();
      element_count = 0;
      lead_score = '0;
      lead_class = '0;
      score_seen = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCORE_THRESHOLD:  regs.score_threshold = data[THR_W-1:0];
        CFG_SCALE_HORIZONTAL: regs.scale_horizontal = data[SCALE_W-1:0];
        CFG_SCALE_VERTICAL:   regs.scale_vertical = data[SCALE_W-1:0];
        CFG_FRAME_WIDTH:      regs.frame_width = data[EXT_W-1:0];
        CFG_FRAME_HEIGHT:     regs.frame_height = data[EXT_W-1:0];
        CFG_CLASS_MASK_LOW:   regs.class_mask[CFG_DATA_W-1:0] = data;
        CFG_CLASS_MASK_HIGH:  regs.class_mask[MASK_W-1:CFG_DATA_W] = data;
        CFG_CLASS_FILTER_ON:  regs.class_filter_on = data[0];
        default: ;
      endcase
    endfunction

    // scale one axis to pixels and clip it to the frame
    function void scale_axis(input logic [VAL_W-1:0] centre, input logic [VAL_W-1:0] size,
                             input logic [SCALE_W-1:0] k, input logic [EXT_W-1:0] extent,
                             output logic [POS_W-1:0] pos, output logic [LEN_W-1:0] len);
      longint ext;
      longint lo;
      longint span;
      longint room;
      if (extent == 0) begin
        ext = 1;
      end else if (extent > EXT_MAX) begin
        ext = EXT_MAX;
      end else begin
        ext = extent;
      end
      lo = (longint'(centre) * 2 - longint'(size)) * longint'(k);
      span = longint'(size) * 2 * longint'(k);
      if (lo < 0) lo = 0;
      room = (ext <<< FRAC_SHIFT) - lo;
      if (span > room) span = room;
      if (span < 0) span = 0;
      lo = lo >>> FRAC_SHIFT;
      if (lo > ext - 1) lo = ext - 1;
      span = span >>> FRAC_SHIFT;
      pos = lo[POS_W-1:0];
      len = span[LEN_W-1:0];
    endfunction

    // one accepted element: box values, running argmax, decision on last
    function void take_element(logic [VAL_W-1:0] value, bit last, bit first);
      int unsigned slot;
      bit          keep;
      result_t     box;
      if (first) begin
        proposal_count = 0;
        start_proposal();
      end
      slot = element_count;
      if (slot < BOX_VALS) begin
        held_box[slot] = value;
      end else if (slot - BOX_VALS < MaxClasses && value > lead_score) begin
        lead_score = value;
        lead_class = CLS_W'(slot - BOX_VALS);
        score_seen = 1'b1;
      end
      if (element_count < CNT_MAX) element_count++;
      if (!last) return;

      proposals_closed++;
      keep = score_seen && (lead_score >= regs.score_threshold);
      if (keep && regs.class_filter_on && !regs.class_mask[lead_class]) keep = 1'b0;
      if (keep) begin
        scale_axis(held_box[0], held_box[2], regs.scale_horizontal, regs.frame_width,
                   box.left, box.width);
        scale_axis(held_box[1], held_box[3], regs.scale_vertical, regs.frame_height,
                   box.top, box.height);
        box.cls = lead_class;
        box.score = lead_score;
        box.num = NUM_W'(proposal_count);
        expected_boxes.insert(expected_boxes.size(), box);
        boxes_predicted++;
      end else begin
        boxes_rejected++;
      end
      proposal_count++;
      if (proposal_count >= MaxProposals) proposal_count = 0;
      start_proposal();
    endfunction

    // one box taken from the block, against the oldest prediction
    function void check_box(result_t got);
      result_t want;
      if (expected_boxes.size() == 0) begin
        failures++;
        if (failures <= MISMATCH_REPORTS)
          $display("unexpected box: l=%0d t=%0d w=%0d h=%0d c=%0d s=%0d n=%0d",
                   got.left, got.top, got.width, got.height, got.cls, got.score, got.num);
        return;
      end
      want = expected_boxes.pop_front();
      boxes_checked++;
      if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
          got.height !== want.height || got.cls !== want.cls ||
          got.score !== want.score || got.num !== want.num) begin
        failures++;
        if (failures <= MISMATCH_REPORTS)
          $display("box mismatch: want l=%0d t=%0d w=%0d h=%0d c=%0d s=%0d n=%0d",
                   want.left, want.top, want.width, want.height, want.cls, want.score,
                   want.num, " got l=%0d t=%0d w=%0d h=%0d c=%0d s=%0d n=%0d",
                   got.left, got.top, got.width, got.height, got.cls, got.score, got.num);
      end
    endfunction

    function void flag_leftovers();
      if (expected_boxes.size() != 0) begin
        failures += expected_boxes.size();
        $display("%0d predicted boxes never came out", expected_boxes.size());
      end
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [VAL_W-1:0]      element_value_i;
  logic                  last_element_i;
  logic                  first_of_frame_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [POS_W-1:0]      box_left_o;
  logic [POS_W-1:0]      box_top_o;
  logic [LEN_W-1:0]      box_width_o;
  logic [LEN_W-1:0]      box_height_o;
  logic [CLS_W-1:0]      class_index_o;
  logic [VAL_W-1:0]      best_score_o;
  logic [NUM_W-1:0]      proposal_number_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  box_scoreboard boxes = new();

  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int unsigned elements_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles = 0;

  detector_proposal_decoder i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .element_value_i   (element_value_i),
    .last_element_i    (last_element_i),
    .first_of_frame_i  (first_of_frame_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .box_left_o        (box_left_o),
    .box_top_o         (box_top_o),
    .box_width_o       (box_width_o),
    .box_height_o      (box_height_o),
    .class_index_o     (class_index_o),
    .best_score_o      (best_score_o),
    .proposal_number_o (proposal_number_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random back pressure on the result side
  always @(negedge clk_i) begin
    out_stall_i = recv_idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // result sampling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      boxes.check_box(result_t'{left: box_left_o, top: box_top_o, width: box_width_o,
                                height: box_height_o, cls: class_index_o,
                                score: best_score_o, num: proposal_number_o});
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [VAL_W-1:0] px(int unsigned pixels);
    return VAL_W'(pixels << 12);
  endfunction

  function automatic logic [VAL_W-1:0] pick_coord();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = VAL_W'($urandom());
      default: v = VAL_W'($urandom_range(0, 700 << 12));
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] pick_score();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = VAL_W'($urandom());
      3:       v = VAL_W'(1 << 12);
      default: v = VAL_W'($urandom_range(0, 8191));
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_class_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return $urandom_range(120, 300);
    if (r < 10) return $urandom_range(1, 3);
    return $urandom_range(1, 20);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(cfg_idx_e r);
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom(), $urandom()};
    case (r)
      CFG_SCORE_THRESHOLD: begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = CFG_DATA_W'(8191);
          2:       v = CFG_DATA_W'(4096);
          3:       ;
          default: v = CFG_DATA_W'($urandom_range(0, 3000));
        endcase
      end
      CFG_SCALE_HORIZONTAL, CFG_SCALE_VERTICAL: begin
        case ($urandom_range(0, 6))
          0:       v = '0;
          1:       v = CFG_DATA_W'(65535);
          2:       v = CFG_DATA_W'(4096);
          3:       ;
          default: v = CFG_DATA_W'($urandom_range(1024, 16384));
        endcase
      end
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
        case ($urandom_range(0, 8))
          0:       v = '0;
          1:       v = CFG_DATA_W'(8191);
          2:       v = CFG_DATA_W'(4096);
          3:       v = CFG_DATA_W'(4097);
          4:       v = CFG_DATA_W'(1);
          default: v = CFG_DATA_W'($urandom_range(1, 4096));
        endcase
      end
      CFG_CLASS_MASK_LOW, CFG_CLASS_MASK_HIGH: begin
        case ($urandom_range(0, 5))
          0, 1:    v = '1;
          2:       v = '0;
          3:       v = CFG_DATA_W'(1) << $urandom_range(0, CFG_DATA_W - 1);
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // one element transfer, with random idle cycles in front
  task automatic push_element(input logic [VAL_W-1:0] value, input bit last, input bit first);
    @(negedge clk_i);
    while (send_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    element_value_i = value;
    last_element_i = last;
    first_of_frame_i = first;
    do @(posedge clk_i); while (in_stall_o);
    boxes.take_element(value, last, first);
    elements_sent++;
  endtask

  // full proposal: four box values, then class scores with frequent ties
  task automatic send_proposal(input int unsigned classes, input bit first);
    logic [VAL_W-1:0] score;
    logic [VAL_W-1:0] prev;
    prev = '0;
    for (int i = 0; i < BOX_VALS; i++) push_element(pick_coord(), 1'b0, first && i == 0);
    for (int unsigned c = 0; c < classes; c++) begin
      score = ($urandom_range(0, 4) == 0) ? prev : pick_score();
      prev = score;
      push_element(score, c == classes - 1, 1'b0);
    end
  endtask

  // proposal that ends before any class score
  task automatic send_short(input int unsigned count, input bit first);
    for (int unsigned i = 0; i < count; i++)
      push_element(pick_coord(), i == count - 1, first && i == 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    boxes.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // hold off the sender until every predicted box has come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (boxes.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure();
    cfg_idx_e r;
    settle();
    r = r.first();
    do begin
      write_reg(r, pick_reg_value(r));
      r = r.next();
    end while (r != r.first());
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    int unsigned phase_start;
    int unsigned phase;
    int unsigned kind;
    int unsigned waited;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    element_value_i = '0;
    last_element_i = 1'b0;
    first_of_frame_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SCORE_THRESHOLD;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: tie between classes two and three, first one wins
    push_element(px(320), 1'b0, 1'b1);
    push_element(px(240), 1'b0, 1'b0);
    push_element(px(100), 1'b0, 1'b0);
    push_element(px(50), 1'b0, 1'b0);
    push_element('0, 1'b0, 1'b0);
    push_element(VAL_W'(1229), 1'b0, 1'b0);
    push_element(VAL_W'(3000), 1'b0, 1'b0);
    push_element(VAL_W'(3000), 1'b1, 1'b0);
    // proposal cut short inside the box values
    push_element(px(10), 1'b0, 1'b0);
    push_element(px(20), 1'b1, 1'b0);
    // winner one below the threshold
    push_element(px(600), 1'b0, 1'b0);
    push_element(px(600), 1'b0, 1'b0);
    push_element(px(100), 1'b0, 1'b0);
    push_element(px(100), 1'b0, 1'b0);
    push_element('0, 1'b0, 1'b0);
    push_element('0, 1'b0, 1'b0);
    push_element(VAL_W'(1228), 1'b1, 1'b0);
    // winner outside the class mask
    push_element('1, 1'b0, 1'b0);
    push_element('1, 1'b0, 1'b0);
    push_element('1, 1'b0, 1'b0);
    push_element('1, 1'b0, 1'b0);
    push_element(VAL_W'(5000), 1'b1, 1'b0);

    // extreme settings: zero and oversized frames, largest scales, no filter
    settle();
    write_reg(CFG_SCORE_THRESHOLD, '0);
    write_reg(CFG_SCALE_HORIZONTAL, CFG_DATA_W'(65535));
    write_reg(CFG_SCALE_VERTICAL, CFG_DATA_W'(65535));
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(8191));
    write_reg(CFG_CLASS_FILTER_ON, '0);
    settings_used++;
    // left edge below zero, top edge past the frame
    push_element('0, 1'b0, 1'b1);
    push_element('1, 1'b0, 1'b0);
    push_element('1, 1'b0, 1'b0);
    push_element('0, 1'b0, 1'b0);
    push_element(VAL_W'(1), 1'b1, 1'b0);

    // random part, starting with a proposal longer than the element counter
    reconfigure();
    random_start = elements_sent;
    phase_start = elements_sent;
    phase = 0;
    send_proposal(300, 1'b1);
    while (elements_sent - random_start < RANDOM_ITEMS) begin
      if (elements_sent - phase_start >= PHASE_ITEMS) begin
        reconfigure();
        phase++;
        send_idle_on = (phase != CALM_PHASE);
        recv_idle_on = (phase != CALM_PHASE);
        phase_start = elements_sent;
      end
      kind = $urandom_range(0, 99);
      if (kind < 84) begin
        send_proposal(pick_class_count(), $urandom_range(0, 9) == 0);
      end else if (kind < 92) begin
        send_short($urandom_range(1, BOX_VALS), $urandom_range(0, 9) == 0);
      end else begin
        // abandoned proposal, restarted by a new frame
        for (int unsigned i = $urandom_range(1, 8); i > 0; i--)
          push_element(pick_score(), 1'b0, 1'b0);
        send_proposal(pick_class_count(), 1'b1);
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (boxes.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    boxes.flag_leftovers();

    $display("run: %0d elements, %0d proposals, %0d boxes checked, %0d proposals dropped",
             elements_sent, boxes.proposals_closed, boxes.boxes_checked, boxes.boxes_rejected);
    $display("run: %0d register writes over %0d settings, with random stalls on both sides",
             reg_writes, settings_used);
    if (boxes.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
